### design/abkf_pkg.sv
// ----------------------------------------------------------------------------
// abkf_pkg
// Shared types, constants and helpers of the angle/bias kalman filter.
// ----------------------------------------------------------------------------
`default_nettype none

package abkf_pkg;

   // data formats
   localparam int DATA_W   = 32;          // q16.16 angles, q2.30 covariance
   localparam int CFG_W    = 31;          // unsigned q1.30 registers
   localparam int MUL_W    = 33;          // serial multiplier operand width
   localparam int PROD_W   = 36;          // rounded product width
   localparam int WIDE_W   = 38;          // headroom for sums before saturation
   localparam int DIV_W    = 62;          // |num| * 2^30
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef logic signed [WIDE_W-1:0] wide_type;

   // register indexes
   localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd0;
   localparam logic [2:0] REG_ANGLE_NOISE   = 3'd1;
   localparam logic [2:0] REG_BIAS_NOISE    = 3'd2;
   localparam logic [2:0] REG_MEAS_NOISE    = 3'd3;
   localparam logic [2:0] REG_WRAP_MODE     = 3'd4;

   // register reset values
   localparam logic [CFG_W-1:0] RST_SAMPLE_PERIOD = 31'd107374182;
   localparam logic [CFG_W-1:0] RST_ANGLE_NOISE   = 31'd1073742;
   localparam logic [CFG_W-1:0] RST_BIAS_NOISE    = 31'd5368709;
   localparam logic [CFG_W-1:0] RST_MEAS_NOISE    = 31'd536870912;

   // angle constants in q16.16 degrees
   localparam logic signed [DATA_W:0]   DEG_300 = 33'sd19660800;
   localparam logic signed [DATA_W+1:0] DEG_360 = 34'sd23592960;
   localparam logic signed [DATA_W-1:0] DEG_180 = 32'sd11796480;
   localparam logic signed [DATA_W-1:0] ONE_Q30 = 32'sd1073741824;

   localparam wide_type SAT_HI = 38'sd2147483647;
   localparam wide_type SAT_LO = -38'sd2147483648;

   typedef struct packed {
      logic                     start;
      logic signed [MUL_W-1:0]  op_a;
      logic signed [MUL_W-1:0]  op_b;
   } mul_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [PROD_W-1:0] product;
   } mul_rsp_type;

   typedef struct packed {
      logic                     start;
      logic signed [DATA_W-1:0] num;
      logic [DATA_W-1:0]        den;
   } div_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [DATA_W-1:0] quotient;
   } div_rsp_type;

   // clamp to the signed 32-bit range
   function automatic logic signed [DATA_W-1:0] sat32(input wide_type v);
      logic signed [DATA_W-1:0] r;
      if (v > SAT_HI) r = 32'sh7fffffff;
      else if (v < SAT_LO) r = 32'sh80000000;
      else r = v[DATA_W-1:0];
      return r;
   endfunction

endpackage

`default_nettype wire

### design/abkf_req_if.sv
// ----------------------------------------------------------------------------
// abkf_req_if
// Input channel: measured angle and gyro rate of one sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface abkf_req_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  measured_angle;
   logic signed [31:0]  gyro_rate;

   modport source (output valid, measured_angle, gyro_rate, input ready);
   modport sink   (input valid, measured_angle, gyro_rate, output ready);
endinterface

`default_nettype wire

### design/abkf_rsp_if.sv
// ----------------------------------------------------------------------------
// abkf_rsp_if
// Result channel: filtered angle, corrected rate and bias.
// ----------------------------------------------------------------------------
`default_nettype none

interface abkf_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  filtered_angle;
   logic signed [31:0]  filtered_rate;
   logic signed [31:0]  rate_bias;

   modport source (output valid, filtered_angle, filtered_rate, rate_bias, input ready);
   modport sink   (input valid, filtered_angle, filtered_rate, rate_bias, output ready);
endinterface

`default_nettype wire

### design/abkf_mul.sv
// ----------------------------------------------------------------------------
// abkf_mul
// Bit-serial signed multiplier, one multiplier bit per cycle, with the
// q2.30 round to nearest (ties up) applied to the finished product.
// ----------------------------------------------------------------------------
`default_nettype none

module abkf_mul (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire abkf_pkg::mul_req_type mul_req,
   output abkf_pkg::mul_rsp_type      mul_rsp
);

   localparam int W   = abkf_pkg::MUL_W;
   localparam int ACC = 2 * W + 1;
   localparam logic [5:0] LAST = 6'(W - 1);

   logic signed [W-1:0] a_ff, a_in;
   logic [ACC-1:0]      acc_ff, acc_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic signed [W:0]   addend;
   logic signed [W:0]   upper;

   // shift-add step, sign bit of the multiplier weighs negative
   always_comb begin
      a_in    = a_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      addend  = '0;
      if (acc_ff[0]) begin
         addend = (cnt_ff == LAST) ? -(34'(a_ff)) : 34'(a_ff);
      end
      upper = $signed(acc_ff[ACC-1:W]) + addend;
      if (mul_req.start) begin
         a_in   = mul_req.op_a;
         acc_in = {{(W+1){1'b0}}, mul_req.op_b};
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         acc_in = {upper[W], upper, acc_ff[W-1:1]};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      acc_ff <= acc_in;
   end

   // floor(p / 2^30) plus the half bit gives round half up
   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = $signed(acc_ff[65:30]) + $signed({35'b0, acc_ff[29]});

endmodule

`default_nettype wire

### design/abkf_div.sv
// ----------------------------------------------------------------------------
// abkf_div
// Restoring divider for the gains: num * 2^30 / den, one quotient bit per
// cycle, truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module abkf_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire abkf_pkg::div_req_type div_req,
   output abkf_pkg::div_rsp_type      div_rsp
);

   localparam int N = abkf_pkg::DIV_W;
   localparam int D = abkf_pkg::DATA_W;
   localparam logic [5:0] LAST = 6'(N - 1);

   logic [N-1:0] dvd_ff, dvd_in;
   logic [D-1:0] rem_ff, rem_in;
   logic [D-1:0] den_ff, den_in;
   logic         neg_ff, neg_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic         run_ff, run_in;
   logic         done_ff, done_in;
   logic [D:0]   rem2;
   logic         ge;
   logic [D-1:0] mag;
   logic         big;

   // one restoring step per cycle, quotient bits shift in from the right
   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      rem2    = {rem_ff, dvd_ff[N-1]};
      ge      = rem2 >= {1'b0, den_ff};
      mag     = div_req.num[D-1] ? D'(-div_req.num) : D'(div_req.num);
      if (div_req.start) begin
         dvd_in = {mag, {(N-D){1'b0}}};
         rem_in = '0;
         den_in = div_req.den;
         neg_in = div_req.num[D-1];
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? D'(rem2 - {1'b0, den_ff}) : rem2[D-1:0];
         dvd_in = {dvd_ff[N-2:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // sign and saturation of the quotient
   always_comb begin
      big = |dvd_ff[N-1:D-1];
      if (neg_ff) begin
         div_rsp.quotient = big ? 32'sh80000000 : -$signed(dvd_ff[D-1:0]);
      end else begin
         div_rsp.quotient = big ? 32'sh7fffffff : $signed(dvd_ff[D-1:0]);
      end
      div_rsp.done = done_ff;
   end

endmodule

`default_nettype wire

### design/angle_bias_kalman_filter.sv
// ----------------------------------------------------------------------------
// angle_bias_kalman_filter
// One axis of a two-state attitude filter tracking angle and gyro bias.
//
// Use: samples (measured_angle, gyro_rate, q16.16) come in on req_chan with
// valid/ready; one result (filtered_angle, filtered_rate, rate_bias) leaves
// on rsp_chan per sample. Registers sit on the apb port csr_*, byte
// address 4*index, and the user must see that they are written only while
// no sample is in flight; the block itself does not enforce this.
// One sample at a time: each takes ten passes through the bit-serial
// multiplier and, when the gain denominator is positive, two passes
// through the restoring gain divider, between accept and output.
// The result register frees the input: a new sample is taken while the last
// result still waits; its result is held back until the old one is taken.
// Reset: synchronous; registers go to their defaults, estimates to zero,
// the variances to one and no result is pending. A stalled receiver simply
// holds the result and, once the next sample is done, the filter.
// ----------------------------------------------------------------------------
`default_nettype none

module angle_bias_kalman_filter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   abkf_req_if.sink                               req_chan,
   abkf_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [abkf_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [abkf_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [abkf_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);

   localparam int D = abkf_pkg::DATA_W;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ISSUE = 5'b00010,
      ST_MUL   = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   // multiplier pass sequence
   localparam logic [3:0] OP_ANG_PRED = 4'd0;
   localparam logic [3:0] OP_PAA_PRED = 4'd1;
   localparam logic [3:0] OP_CROSS_PRED = 4'd2;
   localparam logic [3:0] OP_PBB_PRED = 4'd3;
   localparam logic [3:0] OP_PBA_CORR = 4'd4;
   localparam logic [3:0] OP_PAA_CORR = 4'd5;
   localparam logic [3:0] OP_PBB_CORR = 4'd6;
   localparam logic [3:0] OP_PAB_CORR = 4'd7;
   localparam logic [3:0] OP_ANG_CORR = 4'd8;
   localparam logic [3:0] OP_BIAS_CORR = 4'd9;

   state_type state_ff, state_in;
   logic [3:0] op_ff, op_in;
   logic       div_sel_ff, div_sel_in;

   logic [abkf_pkg::CFG_W-1:0] period_ff, angle_noise_ff, bias_noise_ff, meas_noise_ff;
   logic                       wrap_ff;

   logic signed [D-1:0] ang_ff, ang_in, bias_ff, bias_in;
   logic signed [D-1:0] paa_ff, paa_in, pab_ff, pab_in, pba_ff, pba_in, pbb_ff, pbb_in;
   logic signed [D+1:0] meas_ff, meas_in;
   logic signed [D-1:0] gyro_ff, gyro_in;
   logic signed [D-1:0] rate_ff, rate_in, deriv_ff, deriv_in, err_ff, err_in;
   logic signed [D-1:0] k0_ff, k0_in, k1_ff, k1_in;
   logic signed [D:0]   den_ff, den_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [D-1:0] out_ang_ff, out_ang_in, out_rate_ff, out_rate_in;
   logic signed [D-1:0] out_bias_ff, out_bias_in;

   abkf_pkg::mul_req_type mul_req_ff, mul_req_in;
   abkf_pkg::mul_rsp_type mul_rsp;
   abkf_pkg::div_req_type div_req_ff, div_req_in;
   abkf_pkg::div_rsp_type div_rsp;

   logic signed [abkf_pkg::MUL_W-1:0] sel_a, sel_b;
   abkf_pkg::wide_type                prod;
   logic signed [D:0]                 diff;
   logic signed [D:0]                 den_now;
   logic signed [D-1:0]               folded;
   logic                              csr_write;

   abkf_mul u_mul (.clock(clock), .reset(reset), .mul_req(mul_req_ff), .mul_rsp(mul_rsp));
   abkf_div u_div (.clock(clock), .reset(reset), .div_req(div_req_ff), .div_rsp(div_rsp));

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff      <= abkf_pkg::RST_SAMPLE_PERIOD;
         angle_noise_ff <= abkf_pkg::RST_ANGLE_NOISE;
         bias_noise_ff  <= abkf_pkg::RST_BIAS_NOISE;
         meas_noise_ff  <= abkf_pkg::RST_MEAS_NOISE;
         wrap_ff        <= 1'b0;
      end else if (csr_write) begin
         case (csr_paddr[4:2])
            abkf_pkg::REG_SAMPLE_PERIOD: period_ff      <= csr_pwdata[30:0];
            abkf_pkg::REG_ANGLE_NOISE:   angle_noise_ff <= csr_pwdata[30:0];
            abkf_pkg::REG_BIAS_NOISE:    bias_noise_ff  <= csr_pwdata[30:0];
            abkf_pkg::REG_MEAS_NOISE:    meas_noise_ff  <= csr_pwdata[30:0];
            abkf_pkg::REG_WRAP_MODE:     wrap_ff        <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         abkf_pkg::REG_SAMPLE_PERIOD: csr_prdata = {1'b0, period_ff};
         abkf_pkg::REG_ANGLE_NOISE:   csr_prdata = {1'b0, angle_noise_ff};
         abkf_pkg::REG_BIAS_NOISE:    csr_prdata = {1'b0, bias_noise_ff};
         abkf_pkg::REG_MEAS_NOISE:    csr_prdata = {1'b0, meas_noise_ff};
         abkf_pkg::REG_WRAP_MODE:     csr_prdata = {31'b0, wrap_ff};
         default:                     csr_prdata = '0;
      endcase
   end

   // operands of the current multiplier pass
   always_comb begin
      sel_a = '0;
      sel_b = '0;
      case (op_ff)
         OP_ANG_PRED: begin
            sel_a = 33'(rate_ff);
            sel_b = $signed({2'b0, period_ff});
         end
         OP_PAA_PRED: begin
            sel_a = 33'(deriv_ff);
            sel_b = $signed({2'b0, period_ff});
         end
         OP_CROSS_PRED: begin
            sel_a = -(33'(pbb_ff));
            sel_b = $signed({2'b0, period_ff});
         end
         OP_PBB_PRED: begin
            sel_a = $signed({2'b0, bias_noise_ff});
            sel_b = $signed({2'b0, period_ff});
         end
         OP_PBA_CORR: begin
            sel_a = 33'(k1_ff);
            sel_b = 33'(paa_ff);
         end
         OP_PAA_CORR: begin
            sel_a = 33'(k0_ff);
            sel_b = 33'(paa_ff);
         end
         OP_PBB_CORR: begin
            sel_a = 33'(k1_ff);
            sel_b = 33'(pab_ff);
         end
         OP_PAB_CORR: begin
            sel_a = 33'(k0_ff);
            sel_b = 33'(pab_ff);
         end
         OP_ANG_CORR: begin
            sel_a = 33'(k0_ff);
            sel_b = 33'(err_ff);
         end
         OP_BIAS_CORR: begin
            sel_a = 33'(k1_ff);
            sel_b = 33'(err_ff);
         end
         default: ;
      endcase
   end

   assign prod    = abkf_pkg::wide_type'(mul_rsp.product);
   assign diff    = 33'(req_chan.measured_angle) - 33'(ang_ff);
   assign den_now = $signed({2'b0, meas_noise_ff}) + 33'(paa_ff);

   // heading fold of the corrected angle
   always_comb begin
      folded = ang_ff;
      if (wrap_ff) begin
         if (ang_ff >= abkf_pkg::DEG_180) folded = D'(ang_ff - 32'(abkf_pkg::DEG_360));
         else if (ang_ff < -abkf_pkg::DEG_180) folded = D'(ang_ff + 32'(abkf_pkg::DEG_360));
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      div_sel_in  = div_sel_ff;
      ang_in      = ang_ff;
      bias_in     = bias_ff;
      paa_in      = paa_ff;
      pab_in      = pab_ff;
      pba_in      = pba_ff;
      pbb_in      = pbb_ff;
      meas_in     = meas_ff;
      gyro_in     = gyro_ff;
      rate_in     = rate_ff;
      deriv_in    = deriv_ff;
      err_in      = err_ff;
      k0_in       = k0_ff;
      k1_in       = k1_ff;
      den_in      = den_ff;
      out_ang_in  = out_ang_ff;
      out_rate_in = out_rate_ff;
      out_bias_in = out_bias_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      mul_req_in  = mul_req_ff;
      mul_req_in.start = 1'b0;
      div_req_in  = div_req_ff;
      div_req_in.start = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               // unwrap against the old estimate
               meas_in = 34'(req_chan.measured_angle);
               if (wrap_ff) begin
                  if (diff > abkf_pkg::DEG_300) begin
                     meas_in = 34'(req_chan.measured_angle) - abkf_pkg::DEG_360;
                  end else if (-diff > abkf_pkg::DEG_300) begin
                     meas_in = 34'(req_chan.measured_angle) + abkf_pkg::DEG_360;
                  end
               end
               gyro_in  = req_chan.gyro_rate;
               rate_in  = abkf_pkg::sat32(abkf_pkg::wide_type'(req_chan.gyro_rate)
                                          - abkf_pkg::wide_type'(bias_ff));
               deriv_in = abkf_pkg::sat32($signed({7'b0, angle_noise_ff})
                                          - abkf_pkg::wide_type'(pab_ff)
                                          - abkf_pkg::wide_type'(pba_ff));
               op_in    = OP_ANG_PRED;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            mul_req_in.start = 1'b1;
            mul_req_in.op_a  = sel_a;
            mul_req_in.op_b  = sel_b;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mul_rsp.done) begin
               op_in    = op_ff + 4'd1;
               state_in = ST_ISSUE;
               case (op_ff)
                  OP_ANG_PRED: ang_in = abkf_pkg::sat32(abkf_pkg::wide_type'(ang_ff) + prod);
                  OP_PAA_PRED: begin
                     paa_in = abkf_pkg::sat32(abkf_pkg::wide_type'(paa_ff) + prod);
                     err_in = abkf_pkg::sat32(abkf_pkg::wide_type'(meas_ff)
                                              - abkf_pkg::wide_type'(ang_ff));
                  end
                  OP_CROSS_PRED: begin
                     pab_in = abkf_pkg::sat32(abkf_pkg::wide_type'(pab_ff) + prod);
                     pba_in = abkf_pkg::sat32(abkf_pkg::wide_type'(pba_ff) + prod);
                  end
                  OP_PBB_PRED: begin
                     pbb_in = abkf_pkg::sat32(abkf_pkg::wide_type'(pbb_ff) + prod);
                     den_in = den_now;
                     if (!den_now[D] && den_now != '0) begin
                        div_req_in.start = 1'b1;
                        div_req_in.num   = paa_ff;
                        div_req_in.den   = den_now[D-1:0];
                        div_sel_in = 1'b0;
                        state_in   = ST_DIV;
                     end else begin
                        k0_in = '0;
                        k1_in = '0;
                     end
                  end
                  OP_PBA_CORR: pba_in = abkf_pkg::sat32(abkf_pkg::wide_type'(pba_ff) - prod);
                  OP_PAA_CORR: paa_in = abkf_pkg::sat32(abkf_pkg::wide_type'(paa_ff) - prod);
                  OP_PBB_CORR: pbb_in = abkf_pkg::sat32(abkf_pkg::wide_type'(pbb_ff) - prod);
                  OP_PAB_CORR: pab_in = abkf_pkg::sat32(abkf_pkg::wide_type'(pab_ff) - prod);
                  OP_ANG_CORR: ang_in = abkf_pkg::sat32(abkf_pkg::wide_type'(ang_ff) + prod);
                  OP_BIAS_CORR: begin
                     bias_in  = abkf_pkg::sat32(abkf_pkg::wide_type'(bias_ff) + prod);
                     state_in = ST_OUT;
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (!div_sel_ff) begin
                  k0_in = div_rsp.quotient;
                  div_req_in.start = 1'b1;
                  div_req_in.num   = pba_ff;
                  div_req_in.den   = den_ff[D-1:0];
                  div_sel_in = 1'b1;
               end else begin
                  k1_in    = div_rsp.quotient;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_OUT: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || rsp_chan.ready) begin
               ang_in       = folded;
               out_ang_in   = folded;
               out_bias_in  = bias_ff;
               out_rate_in  = abkf_pkg::sat32(abkf_pkg::wide_type'(gyro_ff)
                                              - abkf_pkg::wide_type'(bias_ff));
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_ANG_PRED;
         div_sel_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mul_req_ff   <= '0;
         div_req_ff   <= '0;
         ang_ff       <= '0;
         bias_ff      <= '0;
         paa_ff       <= abkf_pkg::ONE_Q30;
         pab_ff       <= '0;
         pba_ff       <= '0;
         pbb_ff       <= abkf_pkg::ONE_Q30;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         div_sel_ff   <= div_sel_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_req_ff   <= mul_req_in;
         div_req_ff   <= div_req_in;
         ang_ff       <= ang_in;
         bias_ff      <= bias_in;
         paa_ff       <= paa_in;
         pab_ff       <= pab_in;
         pba_ff       <= pba_in;
         pbb_ff       <= pbb_in;
      end
      meas_ff     <= meas_in;
      gyro_ff     <= gyro_in;
      rate_ff     <= rate_in;
      deriv_ff    <= deriv_in;
      err_ff      <= err_in;
      k0_ff       <= k0_in;
      k1_ff       <= k1_in;
      den_ff      <= den_in;
      out_ang_ff  <= out_ang_in;
      out_rate_ff <= out_rate_in;
      out_bias_ff <= out_bias_in;
   end

   // channels
   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.filtered_angle = out_ang_ff;
   assign rsp_chan.filtered_rate  = out_rate_ff;
   assign rsp_chan.rate_bias      = out_bias_ff;

endmodule

`default_nettype wire

### design/abkf_checker.sv
// ----------------------------------------------------------------------------
// abkf_checker
// Port-level checks of the filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module abkf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_angle
);

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one item at a time: input closes right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");

   // a result never appears the cycle after an accept
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result too early");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_angle))
      else $error("stalled result dropped or changed");

endmodule

bind angle_bias_kalman_filter abkf_checker u_abkf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_angle (rsp_chan.filtered_angle)
);

`default_nettype wire
